// ----- sv/ddo_pkg.sv -----
// Shared types, constants and the quarter-wave sine ROM contents for the
// differential-drive odometry core. No dependencies.
`default_nettype none

package ddo_pkg;

    // Sine ROM geometry
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // Register map
    localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_HEAD_PER_COUNT = 2'd1;
    localparam logic [1:0] REG_RAD_PER_COUNT  = 2'd2;

    localparam logic [23:0] DIST_RESET = 24'd9517;
    localparam logic [30:0] HEAD_RESET = 31'd2584939;
    localparam logic [30:0] RAD_RESET  = 31'd16241626;

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_T,
        ST_MUL_H,
        ST_LUT_C,
        ST_MUL_X,
        ST_MUL_XL,
        ST_ACC_X,
        ST_MUL_YL,
        ST_ACC_Y,
        ST_LIN_K,
        ST_LIN_GO,
        ST_LIN_WAIT,
        ST_LIN_FIN,
        ST_ANG_K,
        ST_ANG_GO,
        ST_ANG_WAIT,
        ST_ANG_FIN,
        ST_QZ,
        ST_QW,
        ST_QDONE,
        ST_OUT
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quo;
    } div_rsp_t;

    // Quarter-wave sine in Q1.14, built from a fixed-point Taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t           t;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        logic signed [63:0]  v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            x    = 64'(i) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            if (sum < 0)
                sum = 0;
            v = (sum + 64'sd32768) >>> 16;
            if (v > 64'sd16384)
                v = 64'sd16384;
            t[i] = v[15:0];
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- sv/ddo_div.sv -----
// Restoring divider, one quotient bit per cycle, 32 steps.
// Depends on ddo_pkg for the request and response structs.
`default_nettype none

module ddo_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ddo_pkg::div_req_t req,
    output      ddo_pkg::div_rsp_t rsp
);
    import ddo_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic        ovf_reg;

    logic [32:0] trial;
    logic        fits;
    logic [32:0] diff_val;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[31]};
        fits     = trial >= {1'b0, den_reg};
        diff_val = trial - {1'b0, den_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.hi;
            quo_reg <= req.lo;
            den_reg <= req.den;
            ovf_reg <= req.hi >= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff_val[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// ----- sv/diff_drive_odometry_core.sv -----
// Differential-drive wheel odometry core: sequencer, shared multiplier, sine ROM.
// Depends on ddo_pkg and ddo_div.
//
// One tick beat carries both absolute encoder counts and a ms time stamp and
// yields one result beat: pose, speeds and yaw quaternion. A tick whose time
// equals the previous one goes straight to the quaternion states; any
// other tick spends almost all of its time in two 32-step runs of the
// shared radix-2 divider (linear, then angular speed). in_ready is high only
// while the core is idle; the next tick is taken once the result beat leaves.
// Configuration writes are always accepted and must only be issued when idle.
`default_nettype none

module diff_drive_odometry_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // config
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // tick in
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [31:0] left_count,
    input  wire logic signed [31:0] right_count,
    input  wire logic [31:0]        time_ms,
    // result out
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] pos_x,
    output      logic signed [31:0] pos_y,
    output      logic signed [31:0] heading,
    output      logic signed [31:0] lin_speed,
    output      logic signed [31:0] ang_speed,
    output      logic signed [15:0] quat_z,
    output      logic signed [15:0] quat_w
);
    import ddo_pkg::*;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    state_t state_reg, state_next;

    logic [23:0] dist_reg;
    logic [30:0] hpc_reg;
    logic [30:0] rpc_reg;

    logic [31:0] prev_left_reg, prev_right_reg, prev_time_reg;
    logic signed [31:0] x_reg, y_reg, lin_reg, angv_reg;
    logic [31:0] ang_acc_reg;

    logic [31:0]        dt_reg;
    logic signed [32:0] sum_reg, diff_reg;
    logic signed [56:0] s_reg;
    logic signed [63:0] turn_reg;
    logic signed [47:0] d_reg;
    logic signed [63:0] prod_reg;
    logic [50:0]        mag_reg;
    logic               neg_reg;
    logic [60:0]        num_reg;
    logic signed [15:0] quat_z_reg, quat_w_reg;

    // ROM pipeline
    logic [15:0]            rom_q_reg;
    logic                   one_reg;
    logic                   negt_reg;
    logic [31:0]            rom_angle;
    logic [SINE_ADDR_W+1:0] phase;
    logic [SINE_ADDR_W-1:0] rom_idx;
    logic [SINE_ADDR_W-1:0] rom_addr;
    logic signed [15:0]     trig_mag;
    logic signed [15:0]     trig_val;

    // 33x32 shared multiplier; travel times trig is done in two halves
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [32:0] d_hi;
    logic signed [32:0] d_lo;

    logic        in_fire;
    logic [31:0] dt_in;
    logic [31:0] dl_in, dr_in;
    logic [31:0] half_angle;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Saturate a wide sum into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Magnitude clamped to 2^50, sign in the top bit
    function automatic logic [51:0] clamp_mag(input logic signed [63:0] v);
        logic [63:0] m;
        logic        n;
        n = v[63];
        m = n ? 64'(-v) : 64'(v);
        if (m > 64'h0004_0000_0000_0000)
            m = 64'h0004_0000_0000_0000;
        return {n, m[50:0]};
    endfunction

    // Signed, saturated result from the unsigned quotient
    function automatic logic signed [31:0] div_fin(
        input logic        n,
        input logic        ovf,
        input logic [31:0] q
    );
        if (n)
        begin
            if (ovf || q > 32'h8000_0000)
                return 32'sh8000_0000;
            else
                return 32'(-q);
        end
        else
        begin
            if (ovf || q[31])
                return 32'sh7FFF_FFFF;
            else
                return q;
        end
    endfunction

    assign in_fire    = in_valid && in_ready;
    assign dt_in      = time_ms - prev_time_reg;
    assign dl_in      = left_count - prev_left_reg;
    assign dr_in      = right_count - prev_right_reg;
    assign half_angle = {ang_acc_reg[31], ang_acc_reg[31:1]};
    assign cfg_ready  = 1'b1;
    assign d_hi       = 33'(signed'(d_reg[47:16]));
    assign d_lo       = {17'd0, d_reg[15:0]};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_RESET;
            hpc_reg  <= HEAD_RESET;
            rpc_reg  <= RAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIST_PER_COUNT: dist_reg <= cfg_data[23:0];
                REG_HEAD_PER_COUNT: hpc_reg  <= cfg_data[30:0];
                REG_RAD_PER_COUNT:  rpc_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) state_next = (dt_in == '0) ? ST_QZ : ST_MUL_S;
            ST_MUL_S:    state_next = ST_MUL_T;
            ST_MUL_T:    state_next = ST_MUL_H;
            ST_MUL_H:    state_next = ST_LUT_C;
            ST_LUT_C:    state_next = ST_MUL_X;
            ST_MUL_X:    state_next = ST_MUL_XL;
            ST_MUL_XL:   state_next = ST_ACC_X;
            ST_ACC_X:    state_next = ST_MUL_YL;
            ST_MUL_YL:   state_next = ST_ACC_Y;
            ST_ACC_Y:    state_next = ST_LIN_K;
            ST_LIN_K:    state_next = ST_LIN_GO;
            ST_LIN_GO:   state_next = ST_LIN_WAIT;
            ST_LIN_WAIT: if (div_rsp.done) state_next = ST_LIN_FIN;
            ST_LIN_FIN:  state_next = ST_ANG_K;
            ST_ANG_K:    state_next = ST_ANG_GO;
            ST_ANG_GO:   state_next = ST_ANG_WAIT;
            ST_ANG_WAIT: if (div_rsp.done) state_next = ST_ANG_FIN;
            ST_ANG_FIN:  state_next = ST_QZ;
            ST_QZ:       state_next = ST_QW;
            ST_QW:       state_next = ST_QDONE;
            ST_QDONE:    state_next = ST_OUT;
            ST_OUT:      if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Unit selects per state
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        rom_angle   = ang_acc_reg;
        div_req     = '0;
        div_req.den = dt_reg;
        unique case (state_reg)
            ST_MUL_S:
            begin
                mul_a = sum_reg;
                mul_b = {8'd0, dist_reg};
            end
            ST_MUL_T:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, rpc_reg};
            end
            ST_MUL_H:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, hpc_reg};
            end
            ST_LUT_C: rom_angle = ang_acc_reg + QUARTER_TURN;
            // keep cosine in the ROM register for the low half
            ST_MUL_X:
            begin
                rom_angle = ang_acc_reg + QUARTER_TURN;
                mul_a     = d_hi;
                mul_b     = 32'(trig_val);
            end
            ST_ACC_X:
            begin
                mul_a = d_hi;
                mul_b = 32'(trig_val);
            end
            ST_MUL_XL, ST_MUL_YL:
            begin
                mul_a = d_lo;
                mul_b = 32'(trig_val);
            end
            ST_LIN_GO:
            begin
                div_req.start = 1'b1;
                div_req.hi    = {12'd0, num_reg[60:41]};
                div_req.lo    = num_reg[40:9];
            end
            ST_ANG_GO:
            begin
                div_req.start = 1'b1;
                div_req.hi    = {19'd0, num_reg[60:48]};
                div_req.lo    = num_reg[47:16];
            end
            ST_QZ: rom_angle = half_angle;
            ST_QW: rom_angle = half_angle + QUARTER_TURN;
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Sine ROM: quadrant fold on the way in, sign and peak on the way out
    assign phase    = rom_angle[31 -: SINE_ADDR_W + 2];
    assign rom_idx  = phase[SINE_ADDR_W-1:0];
    assign rom_addr = phase[SINE_ADDR_W] ? SINE_ADDR_W'(~rom_idx + 1'b1) : rom_idx;
    assign trig_mag = one_reg ? Q14_ONE : signed'(rom_q_reg);
    assign trig_val = negt_reg ? -trig_mag : trig_mag;

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
        one_reg   <= phase[SINE_ADDR_W] && (rom_idx == '0);
        negt_reg  <= phase[SINE_ADDR_W+1];
    end

    // Odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_time_reg  <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            ang_acc_reg    <= '0;
            lin_reg        <= '0;
            angv_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_fire && dt_in != '0)
                    begin
                        prev_left_reg  <= left_count;
                        prev_right_reg <= right_count;
                        prev_time_reg  <= time_ms;
                    end
                ST_MUL_H: ang_acc_reg <= ang_acc_reg + mul_p[31:0];
                ST_ACC_X: x_reg <= sat32(66'(x_reg) + 66'((prod_reg + 64'sd8192) >>> 14));
                ST_ACC_Y: y_reg <= sat32(66'(y_reg) + 66'((prod_reg + 64'sd8192) >>> 14));
                ST_LIN_FIN: lin_reg <= div_fin(neg_reg, div_rsp.ovf, div_rsp.quo);
                ST_ANG_FIN: angv_reg <= div_fin(neg_reg, div_rsp.ovf, div_rsp.quo);
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                dt_reg   <= dt_in;
                sum_reg  <= 33'(signed'(dl_in)) + 33'(signed'(dr_in));
                diff_reg <= 33'(signed'(dr_in)) - 33'(signed'(dl_in));
            end
            ST_MUL_S: s_reg <= mul_p[56:0];
            ST_MUL_T: turn_reg <= mul_p[63:0];
            ST_MUL_H: d_reg <= 48'((s_reg + 57'sd256) >>> 9);
            // high half first, then shift it up and add the low half
            ST_MUL_X: prod_reg <= mul_p[63:0];
            ST_MUL_XL: prod_reg <= (prod_reg <<< 16) + mul_p[63:0];
            ST_ACC_X: prod_reg <= mul_p[63:0];
            ST_MUL_YL: prod_reg <= (prod_reg <<< 16) + mul_p[63:0];
            ST_ACC_Y: {neg_reg, mag_reg} <= clamp_mag(64'(s_reg));
            ST_LIN_K, ST_ANG_K: num_reg <= 61'(mag_reg) * 61'd1000;
            ST_LIN_FIN: {neg_reg, mag_reg} <= clamp_mag(turn_reg);
            ST_QW: quat_z_reg <= trig_val;
            ST_QDONE: quat_w_reg <= trig_val;
            default: ;
        endcase
    end

    ddo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake and result
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign pos_x     = x_reg;
    assign pos_y     = y_reg;
    assign heading   = ang_acc_reg;
    assign lin_speed = lin_reg;
    assign ang_speed = angv_reg;
    assign quat_z    = quat_z_reg;
    assign quat_w    = quat_w_reg;

    // Checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input and output sides open together");

    a_lin_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIN_FIN |-> $past(div_rsp.done))
        else $error("linear speed taken before divider finished");

    a_zero_dt_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && time_ms == prev_time_reg) |=> state_reg == ST_QZ)
        else $error("zero elapsed time tick did not skip the update");

endmodule

`default_nettype wire

// ----- tb/tb_diff_drive_odometry_core.sv -----
// Self-checking testbench for diff_drive_odometry_core: directed ticks, then random ticks
// under three handshake idle patterns, each checked against an in-bench odometry predictor.
// Depends on ddo_pkg and the core RTL.
`default_nettype none

module tb_diff_drive_odometry_core;
    import ddo_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] hd;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } pose_t;

    // directed row: tick fields, plus heading/quaternion typed in where obvious
    typedef struct {
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic [31:0]        t;
        bit                 typed;
        logic signed [31:0] hd;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } tick_row_t;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint SPD_LIM = 64'sd1125899906842624;
    localparam int     N_DIR   = 10;
    localparam int     N_RAND  = 250;
    // index past the register list, writes to it are dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        time_ms;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_speed;
    logic signed [31:0] ang_speed;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    diff_drive_odometry_core dut (.*);

    // predictor state and registers
    logic [23:0] m_dist;
    logic [30:0] m_head;
    logic [30:0] m_rad;
    logic [31:0] m_prev_l;
    logic [31:0] m_prev_r;
    logic [31:0] m_prev_t;
    logic [31:0] m_angle;
    logic signed [31:0] m_x;
    logic signed [31:0] m_y;
    logic signed [31:0] m_lin;
    logic signed [31:0] m_ang;
    longint sine_lut [SINE_TABLE_DEPTH];

    pose_t pending_poses [$];
    int    n_err;
    int    in_idle_pct;
    int    out_idle_pct;
    int    out_hold;

    tick_row_t dir_rows [N_DIR] = '{
        // reset state, zero elapsed time
        '{32'sd0, 32'sd0, 32'd0, 1'b1, 32'sd0, 16'sd0, 16'sd16384},
        // diff of 2 at a quarter turn per count: half turn
        '{32'sd0, 32'sd2, 32'd10, 1'b1, -32'sd2147483648, -16'sd16384, 16'sd0},
        '{32'sd0, 32'sd4, 32'd20, 1'b1, 32'sd0, 16'sd0, 16'sd16384},
        '{32'sd100, 32'sd104, 32'd40, 1'b1, 32'sd0, 16'sd0, 16'sd16384},
        '{32'sd100, 32'sd104, 32'd40, 1'b1, 32'sd0, 16'sd0, 16'sd16384},
        '{-32'sd2147483648, 32'sd2147483647, 32'd41, 1'b0, 0, 0, 0},
        '{32'sd2147483647, -32'sd2147483648, 32'd42, 1'b0, 0, 0, 0},
        '{32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b0, 0, 0, 0},
        '{32'sd5, -32'sd5, 32'd0, 1'b0, 0, 0, 0},
        '{32'sd900, 32'sd1300, 32'd1, 1'b0, 0, 0, 0}
    };

    function automatic longint rnd_shr(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint sat32(longint v);
        return v > I32_MAX ? I32_MAX : (v < I32_MIN ? I32_MIN : v);
    endfunction

    function automatic longint clamp_spd(longint v);
        return v > SPD_LIM ? SPD_LIM : (v < -SPD_LIM ? -SPD_LIM : v);
    endfunction

    // quarter-wave Taylor series, Q30 argument, rounded to Q14
    function automatic void fill_sine_lut();
        longint unsigned xa;
        longint unsigned xsq;
        longint unsigned tm;
        longint          acc;
        longint          q14;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            xa  = longint'(i) * 64'd1686629713 / SINE_TABLE_DEPTH;
            xsq = (xa * xa) >> 30;
            tm  = xa;
            acc = xa;
            for (int k = 1; k <= 6; k++)
            begin
                tm = ((tm * xsq) >> 30) / ((2 * k) * (2 * k + 1));
                acc = (k % 2) ? acc - longint'(tm) : acc + longint'(tm);
            end
            if (acc < 0)
                acc = 0;
            q14 = (acc + 32768) >>> 16;
            sine_lut[i] = q14 > 16384 ? 16384 : q14;
        end
    endfunction

    function automatic longint sin_q14(logic [31:0] a);
        longint unsigned ph;
        longint unsigned quad;
        longint unsigned ofs;
        longint          v;
        ph   = ({32'b0, a} * (4 * SINE_TABLE_DEPTH)) >> 32;
        quad = (ph / SINE_TABLE_DEPTH) & 3;
        ofs  = ph % SINE_TABLE_DEPTH;
        if (quad == 0 || quad == 2)
            v = sine_lut[ofs];
        else
            v = (ofs == 0) ? 16384 : sine_lut[SINE_TABLE_DEPTH - ofs];
        return quad >= 2 ? -v : v;
    endfunction

    // advance odometry by one tick and return the pose it reports
    function automatic pose_t odometry_step(logic [31:0] l, logic [31:0] r, logic [31:0] t);
        logic [31:0] dt;
        logic [31:0] dl32;
        logic [31:0] dr32;
        logic [31:0] half;
        longint      dl;
        longint      dr;
        longint      diff;
        longint      s;
        longint      d;
        longint      turn;
        longint      dt64;
        pose_t       p;
        dt = t - m_prev_t;
        if (dt != 0)
        begin
            dl32 = l - m_prev_l;
            dr32 = r - m_prev_r;
            dl   = longint'(signed'(dl32));
            dr   = longint'(signed'(dr32));
            diff = dr - dl;
            s    = (dl + dr) * longint'({40'b0, m_dist});
            d    = rnd_shr(s, 9);
            turn = diff * longint'({33'b0, m_rad});
            dt64 = longint'({32'b0, dt});
            m_angle = m_angle + diff[31:0] * {1'b0, m_head};
            m_x   = 32'(sat32(longint'(m_x)
                    + rnd_shr(d * sin_q14(m_angle + 32'h4000_0000), 14)));
            m_y   = 32'(sat32(longint'(m_y) + rnd_shr(d * sin_q14(m_angle), 14)));
            m_lin = 32'(sat32(clamp_spd(s) * 1000 / (512 * dt64)));
            m_ang = 32'(sat32(clamp_spd(turn) * 1000 / (65536 * dt64)));
            m_prev_l = l;
            m_prev_r = r;
            m_prev_t = t;
        end
        half = {m_angle[31], m_angle[31:1]};
        p.x   = m_x;
        p.y   = m_y;
        p.hd  = m_angle;
        p.lin = m_lin;
        p.ang = m_ang;
        p.qz  = 16'(sin_q14(half));
        p.qw  = 16'(sin_q14(half + 32'h4000_0000));
        return p;
    endfunction

    function automatic void flag_mismatch(string what, longint exp_v, longint act_v);
        n_err++;
        if (n_err <= 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: compare each beat, random stalls, long hold on request
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
                flag_mismatch("unexpected beat, pos_x", 0, pos_x);
            else
            begin
                e = pending_poses.pop_front();
                if (pos_x !== e.x)       flag_mismatch("pos_x", e.x, pos_x);
                if (pos_y !== e.y)       flag_mismatch("pos_y", e.y, pos_y);
                if (heading !== e.hd)    flag_mismatch("heading", e.hd, heading);
                if (lin_speed !== e.lin) flag_mismatch("lin_speed", e.lin, lin_speed);
                if (ang_speed !== e.ang) flag_mismatch("ang_speed", e.ang, ang_speed);
                if (quat_z !== e.qz)     flag_mismatch("quat_z", e.qz, quat_z);
                if (quat_w !== e.qw)     flag_mismatch("quat_w", e.qw, quat_w);
            end
        end
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // offer one tick beat; valid stays high into the next call unless it idles
    task automatic send_tick(logic [31:0] l, logic [31:0] r, logic [31:0] t);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        left_count  <= l;
        right_count <= r;
        time_ms     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_poses.push_back(odometry_step(l, r, t));
    endtask

    // wait until every result is back, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DIST_PER_COUNT: m_dist = val[23:0];
            REG_HEAD_PER_COUNT: m_head = val[30:0];
            REG_RAD_PER_COUNT:  m_rad  = val[30:0];
            default: ;
        endcase
    endtask

    task automatic random_tick();
        int          kind;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            // normal motion: small count steps, time moving forward
            l = m_prev_l + $urandom_range(400) - 200;
            r = m_prev_r + $urandom_range(400) - 200;
            t = m_prev_t + $urandom_range(60, 1);
        end
        else if (kind < 80)
        begin
            l = $urandom();
            r = $urandom();
            t = m_prev_t;
        end
        else if (kind < 90)
        begin
            l = m_prev_l + $urandom_range(20000) - 10000;
            r = m_prev_r + $urandom_range(20000) - 10000;
            t = m_prev_t + 1;
        end
        else
        begin
            l = $urandom();
            r = $urandom();
            t = $urandom();
        end
        send_tick(l, r, t);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        left_count  = '0;
        right_count = '0;
        time_ms     = '0;
        out_ready   = 1'b0;
        out_hold    = 0;
        n_err       = 0;
        in_idle_pct = 24;
        out_idle_pct = 61;
        m_dist = DIST_RESET;
        m_head = HEAD_RESET;
        m_rad  = RAD_RESET;
        m_prev_l = '0;
        m_prev_r = '0;
        m_prev_t = '0;
        m_angle = '0;
        m_x = '0;
        m_y = '0;
        m_lin = '0;
        m_ang = '0;
        fill_sine_lut();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a quarter turn per count of difference
        write_reg(REG_HEAD_PER_COUNT, 32'h4000_0000);
        foreach (dir_rows[i])
        begin
            send_tick(dir_rows[i].l, dir_rows[i].r, dir_rows[i].t);
            if (dir_rows[i].typed)
            begin
                if (pending_poses[$].hd !== dir_rows[i].hd)
                    flag_mismatch("typed heading", dir_rows[i].hd, pending_poses[$].hd);
                if (pending_poses[$].qz !== dir_rows[i].qz)
                    flag_mismatch("typed quat_z", dir_rows[i].qz, pending_poses[$].qz);
                if (pending_poses[$].qw !== dir_rows[i].qw)
                    flag_mismatch("typed quat_w", dir_rows[i].qw, pending_poses[$].qw);
            end
        end
        drain();

        // three random phases, each with its own register setting and idle pattern
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_DIST_PER_COUNT, 32'hFFFF_FFFF);
                    write_reg(REG_HEAD_PER_COUNT, 32'hFFFF_FFFF);
                    write_reg(REG_RAD_PER_COUNT, 32'h7FFF_FFFF);
                    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
                    in_idle_pct = 24;
                    out_idle_pct = 61;
                end
                1:
                begin
                    write_reg(REG_DIST_PER_COUNT, 32'hA500_0000);
                    write_reg(REG_HEAD_PER_COUNT, $urandom());
                    write_reg(REG_RAD_PER_COUNT, 32'h8000_0000);
                    in_idle_pct = 61;
                    out_idle_pct = 24;
                end
                default:
                begin
                    write_reg(REG_DIST_PER_COUNT, {8'h5A, DIST_RESET});
                    write_reg(REG_HEAD_PER_COUNT, {1'b1, HEAD_RESET});
                    write_reg(REG_RAD_PER_COUNT, {1'b0, RAD_RESET});
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < N_RAND; n++)
            begin
                // long result stall while ticks keep coming
                if (n == 40)
                    out_hold = 400;
                random_tick();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (n_err == 0 && pending_poses.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
